// ===== sv/ckbh_pkg.sv =====
package ckbh_pkg;

  // one input transaction
  typedef struct packed {
    logic [7:0] key_byte;
    logic       has_byte;
    logic       last;
  } in_item_t;

  // one result transaction
  typedef struct packed {
    logic [31:0] hash_value;
    logic [31:0] bucket;
  } out_item_t;

  // status of the queue between front and back
  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  // back end sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIN,
    ST_MIX1,
    ST_MIX2,
    ST_DIV,
    ST_DONE
  } back_state_t;

  localparam logic [31:0] TABLE_SIZE_RST = 32'd1024;
  localparam logic [7:0]  CASE_OFFSET    = 8'h20;

  // one-at-a-time finalization
  function automatic logic [31:0] oaat_final(input logic [31:0] h_in);
    logic [31:0] h;
    h = h_in;
    h = h + (h << 3);
    h = h ^ (h >> 11);
    h = h + (h << 15);
    return h;
  endfunction

  // first half of the extra mixing pass
  function automatic logic [31:0] mix_first(input logic [31:0] m_in);
    logic [31:0] m;
    m = m_in;
    m = m + ~(m << 9);
    m = m ^ {m[13:0], m[31:14]};
    return m;
  endfunction

  // second half of the extra mixing pass
  function automatic logic [31:0] mix_second(input logic [31:0] m_in);
    logic [31:0] m;
    m = m_in;
    m = m + (m << 4);
    m = m ^ {m[9:0], m[31:10]};
    return m;
  endfunction

endpackage

// ===== sv/case_folded_key_bucket_hash.sv =====
// Case-folded key hash with bucket index.
// Input channel: one key byte per transaction with has_byte and last flags,
// taken on in_push while in_full is low. Bytes A..Z are folded to lower case
// and mixed into a one-at-a-time accumulator, one byte per cycle.
// Result channel: one transaction per key (an item with last set), shown on
// out_data while out_empty is low and taken on out_pop. hash_value is the
// finalized one-at-a-time hash; bucket is the remixed hash modulo table_size
// (0 when table_size is 0).
// Config: cfg_we writes table_size from cfg_wdata (reset 1024). The user must
// write it only while idle; the block does not enforce this. Back end states:
// FIN, MIX1, MIX2, DIV (skipped with table_size 0), DONE. Throughput: one byte
// per cycle while in_full is low. The back end takes no new key until the
// last result is popped; its bit-serial restoring divider gives one quotient
// bit per cycle. A queue of QUEUE_DEPTH finished keys lets bytes keep flowing
// meanwhile. A stalled receiver holds the result; the queue then fills and
// in_full rises. Reset clears the accumulator, the queue and the sequencer.
module case_folded_key_bucket_hash #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  ckbh_pkg::in_item_t  in_data,
  output logic                out_empty,
  input  logic                out_pop,
  output ckbh_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [31:0]         cfg_wdata
);
  import ckbh_pkg::*;

  logic [31:0] table_size_r;
  q_stat_t     q_stat;
  logic        q_push;
  logic        q_pop;
  logic [31:0] q_wdata;
  logic [31:0] q_rdata;

  // table size register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_size_r <= TABLE_SIZE_RST;
    end else if (cfg_we) begin
      table_size_r <= cfg_wdata;
    end
  end

  ckbh_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_data (in_data),
    .q_stat  (q_stat),
    .in_full (in_full),
    .q_push  (q_push),
    .q_wdata (q_wdata)
  );

  ckbh_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  ckbh_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .table_size (table_size_r),
    .q_stat     (q_stat),
    .q_rdata    (q_rdata),
    .q_pop      (q_pop),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_data   (out_data)
  );

endmodule

// ===== sv/ckbh_front.sv =====
module ckbh_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  ckbh_pkg::in_item_t in_data,
  input  ckbh_pkg::q_stat_t  q_stat,
  output logic               in_full,
  output logic               q_push,
  output logic [31:0]        q_wdata
);
  import ckbh_pkg::*;

  logic [31:0] acc_r;
  logic [31:0] acc_nxt;
  logic [7:0]  folded;
  logic [31:0] acc_add;
  logic [31:0] acc_sh;
  logic [31:0] acc_step;
  logic        accept;

  // fold ascii upper case and run one accumulator step
  always_comb begin
    folded   = (in_data.key_byte inside {[8'h41:8'h5A]}) ?
               (in_data.key_byte + CASE_OFFSET) : in_data.key_byte;
    acc_add  = acc_r + {24'd0, folded};
    acc_sh   = acc_add + (acc_add << 10);
    acc_step = in_data.has_byte ? (acc_sh ^ (acc_sh >> 5)) : acc_r;
  end

  // handshake and hand-off of a finished key to the queue
  always_comb begin
    in_full = q_stat.full;
    accept  = in_push & ~q_stat.full;
    q_push  = accept & in_data.last;
    q_wdata = acc_step;
    acc_nxt = acc_r;
    if (accept) begin
      acc_nxt = in_data.last ? 32'd0 : acc_step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= 32'd0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

endmodule

// ===== sv/ckbh_fifo.sv =====
module ckbh_fifo #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [31:0]       wdata,
  input  logic              pop,
  output logic [31:0]       rdata,
  output ckbh_pkg::q_stat_t stat
);
  import ckbh_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [31:0]   mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push;
  logic          do_pop;

  // status and pointer updates
  always_comb begin
    stat.empty = (cnt_r == '0);
    stat.full  = (cnt_r == FULL_CNT);
    do_push    = push & ~stat.full;
    do_pop     = pop & ~stat.empty;
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_IDX) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_IDX) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  assign rdata = mem[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // the front never offers a finished key to a full queue
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !stat.full)
    else $error("push into full queue");

  // fill count stays within depth
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL_CNT)
    else $error("queue count out of range");

  // a push alone grows the count by one
  a_cnt_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> cnt_r == $past(cnt_r) + CW'(1))
    else $error("queue count did not grow");

endmodule

// ===== sv/ckbh_back.sv =====
module ckbh_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [31:0]         table_size,
  input  ckbh_pkg::q_stat_t   q_stat,
  input  logic [31:0]         q_rdata,
  output logic                q_pop,
  output logic                out_empty,
  input  logic                out_pop,
  output ckbh_pkg::out_item_t out_data
);
  import ckbh_pkg::*;

  back_state_t state_r, state_nxt;
  logic [31:0] hash_r;
  logic [31:0] m_r;
  logic [31:0] rem_r;
  logic [4:0]  cnt_r;
  logic [32:0] trial;
  logic [32:0] diff;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (!q_stat.empty) state_nxt = ST_FIN;
      end
      ST_FIN:  state_nxt = ST_MIX1;
      ST_MIX1: state_nxt = ST_MIX2;
      ST_MIX2: state_nxt = (table_size == 32'd0) ? ST_DONE : ST_DIV;
      ST_DIV: begin
        if (cnt_r == 5'd0) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_pop) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_pop               = (state_r == ST_IDLE) && !q_stat.empty;
    out_empty           = (state_r != ST_DONE);
    out_data.hash_value = hash_r;
    out_data.bucket     = rem_r;
  end

  // one restoring division step
  always_comb begin
    trial = {rem_r, m_r[cnt_r]};
    diff  = trial - {1'b0, table_size};
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: hash_r <= q_rdata;
      ST_FIN: begin
        hash_r <= oaat_final(hash_r);
        m_r    <= oaat_final(hash_r);
      end
      ST_MIX1: m_r <= mix_first(m_r);
      ST_MIX2: begin
        m_r   <= mix_second(m_r);
        rem_r <= 32'd0;
        cnt_r <= 5'd31;
      end
      ST_DIV: begin
        rem_r <= diff[32] ? trial[31:0] : diff[31:0];
        cnt_r <= cnt_r - 5'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // partial remainder stays below the divisor
  a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> rem_r < table_size)
    else $error("partial remainder not below divisor");

  // a finished bucket is a valid table index
  a_bucket_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && table_size != 32'd0) |-> out_data.bucket < table_size)
    else $error("bucket out of range");

  // a result appears only after the mixing or the division
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_empty) |-> ($past(state_r) == ST_DIV || $past(state_r) == ST_MIX2))
    else $error("result shown without computation");

endmodule

// ===== tb/testbench.sv =====
module testbench;
  import ckbh_pkg::*;

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam int         SETTLE_CYCLES = 45;
  localparam int         RANDOM_ITEMS = 1700;

  logic        clk;
  logic        rst_n;
  logic        in_push;
  logic        in_full;
  in_item_t    in_data;
  logic        out_empty;
  logic        out_pop;
  out_item_t   out_data;
  logic        cfg_we;
  logic [31:0] cfg_wdata;

  // model state
  logic [31:0] key_acc;
  logic [31:0] bucket_count;
  out_item_t   key_results_q[$];

  // run control and statistics
  bit idle_en;
  int hold_req;
  int hold_left;
  int stall_left;
  int errors;
  int keys_sent;
  int items_sent;
  int results_checked;
  int full_cycles;
  int random_items;

  case_folded_key_bucket_hash dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // clock
  always #5 clk = ~clk;

  // run limit
  initial begin
    #5_000_000;
    $display("timeout at %0t", $time);
    $display("status: fail");
    $finish;
  end

  // predictor helpers
  function automatic logic [31:0] fold_case(input logic [7:0] b);
    if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) begin
      return {24'd0, b} + {24'd0, CASE_OFFSET};
    end
    return {24'd0, b};
  endfunction

  function automatic logic [31:0] absorb_byte(input logic [31:0] acc, input logic [31:0] b);
    logic [31:0] a;
    a = acc + b;
    a = a + (a << 10);
    a = a ^ (a >> 5);
    return a;
  endfunction

  function automatic logic [31:0] seal_hash(input logic [31:0] acc);
    logic [31:0] h;
    h = acc + (acc << 3);
    h = h ^ (h >> 11);
    h = h + (h << 15);
    return h;
  endfunction

  function automatic logic [31:0] rot_right(input logic [31:0] v, input int n);
    logic [63:0] both;
    both = {v, v} >> n;
    return both[31:0];
  endfunction

  function automatic logic [31:0] scramble_hash(input logic [31:0] h);
    logic [31:0] m;
    m = h + ~(h << 9);
    m = m ^ rot_right(m, 14);
    m = m + (m << 4);
    m = m ^ rot_right(m, 10);
    return m;
  endfunction

  function automatic in_item_t key_item(input logic [7:0] b, input bit has, input bit last);
    in_item_t it;
    it.key_byte = b;
    it.has_byte = has;
    it.last     = last;
    return it;
  endfunction

  // update the model for one accepted transaction
  task automatic hash_key_item(input in_item_t it);
    logic [31:0] h;
    logic [31:0] m;
    out_item_t   r;
    if (it.has_byte) begin
      key_acc = absorb_byte(key_acc, fold_case(it.key_byte));
    end
    if (it.last) begin
      h = seal_hash(key_acc);
      key_acc = '0;
      m = scramble_hash(h);
      r.hash_value = h;
      r.bucket = (bucket_count == 0) ? 32'd0 : m % bucket_count;
      key_results_q.push_back(r);
      keys_sent++;
    end
  endtask

  // offer one transaction and wait until it is taken
  task automatic send_item(input in_item_t it);
    int gap;
    if (idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 11);
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_full);
    hash_key_item(it);
    items_sent++;
    random_items++;
  endtask

  // stop offering and wait for every pending result, then let the back end settle
  task automatic wait_results_done();
    in_push <= 1'b0;
    while (key_results_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // only called while the block is idle
  task automatic set_table_size(input logic [31:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    bucket_count = v;
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 3))
      0: return CHAR_UPPER_A + 8'($urandom_range(0, 25));
      1: return CHAR_LOWER_A + 8'($urandom_range(0, 25));
      2: return 8'($urandom_range(8'h20, 8'h7F));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // one key with random content, stray idle transactions and terminator style
  task automatic send_random_key();
    int  len;
    bit  use_term;
    len = ($urandom_range(0, 19) == 0) ? $urandom_range(11, 40) : $urandom_range(0, 10);
    use_term = (len == 0) || ($urandom_range(0, 5) == 0);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item(key_item(8'($urandom_range(0, 255)), 1'b0, 1'b0));
      end
      send_item(key_item(pick_byte(), 1'b1, (i == len - 1) && !use_term));
    end
    if (use_term) begin
      send_item(key_item(8'($urandom_range(0, 255)), 1'b0, 1'b1));
    end
  endtask

  // result checker and receiver stall generator
  initial begin : result_monitor
    out_item_t want;
    forever begin
      @(posedge clk);
      if (in_push && in_full) full_cycles++;
      if (rst_n && out_pop && !out_empty) begin
        if (key_results_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual hash %h bucket %h",
                   $time, out_data.hash_value, out_data.bucket);
        end else begin
          want = key_results_q.pop_front();
          results_checked++;
          if (out_data.hash_value !== want.hash_value) begin
            errors++;
            $display("%0t: hash_value mismatch, expected %h, actual %h",
                     $time, want.hash_value, out_data.hash_value);
          end
          if (out_data.bucket !== want.bucket) begin
            errors++;
            $display("%0t: bucket mismatch, expected %h, actual %h",
                     $time, want.bucket, out_data.bucket);
          end
        end
      end
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_pop <= 1'b0;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 10);
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // empty keys, ignored transactions and a terminator after bytes
  task automatic test_empty_and_idle_items();
    send_item(key_item(8'h00, 1'b0, 1'b1));
    send_item(key_item(8'hA5, 1'b0, 1'b0));
    send_item(key_item("Q", 1'b1, 1'b1));
    send_item(key_item("A", 1'b1, 1'b0));
    send_item(key_item(8'hFF, 1'b0, 1'b0));
    send_item(key_item("b", 1'b1, 1'b0));
    send_item(key_item(8'h5A, 1'b0, 1'b1));
  endtask

  // bytes around the folded range, zero and high bytes
  task automatic test_case_folding();
    logic [7:0] edges[12];
    edges = '{8'h40, CHAR_UPPER_A, CHAR_UPPER_Z, 8'h5B, 8'h60, CHAR_LOWER_A,
              CHAR_LOWER_Z, 8'h7B, 8'h00, 8'h7F, 8'h80, 8'hFF};
    foreach (edges[i]) send_item(key_item(edges[i], 1'b1, 1'b1));
  endtask

  // bucket divisor at its extremes, including zero
  task automatic test_table_size_extremes();
    logic [31:0] sizes[4];
    sizes = '{32'd1, 32'd0, 32'hFFFF_FFFF, 32'h8000_0000};
    foreach (sizes[i]) begin
      wait_results_done();
      set_table_size(sizes[i]);
      send_item(key_item(8'h00, 1'b0, 1'b1));
      send_item(key_item(8'hFF, 1'b1, 1'b1));
    end
    wait_results_done();
  endtask

  // receiver holds off while short keys keep coming, so the queue fills
  task automatic test_output_backpressure();
    wait_results_done();
    set_table_size(32'd97);
    hold_req = 400;
    for (int i = 0; i < 30; i++) begin
      send_item(key_item(pick_byte(), 1'b1, 1'b1));
    end
    wait_results_done();
  endtask

  // sender stops mid-stream until every result is in, then resumes
  task automatic test_sender_pause();
    for (int i = 0; i < 6; i++) send_random_key();
    wait_results_done();
    for (int i = 0; i < 6; i++) send_random_key();
  endtask

  // random keys over several table sizes, last phase without idling
  task automatic test_random_traffic();
    logic [31:0] sizes[7];
    int          per_phase;
    int          start;
    sizes = '{TABLE_SIZE_RST, 32'd1, 32'd0, 32'hFFFF_FFFF,
              32'($urandom_range(2, 97)), $urandom, 32'h8000_0000};
    per_phase = RANDOM_ITEMS / ($size(sizes) + 1);
    foreach (sizes[i]) begin
      wait_results_done();
      set_table_size(sizes[i]);
      start = random_items;
      while (random_items - start < per_phase) send_random_key();
    end
    wait_results_done();
    idle_en = 1'b0;
    set_table_size(32'($urandom_range(1000, 5000)));
    start = random_items;
    while (random_items - start < per_phase) send_random_key();
    wait_results_done();
  endtask

  // main sequence
  initial begin
    clk          = 1'b0;
    rst_n        = 1'b0;
    in_push      = 1'b0;
    in_data      = '0;
    out_pop      = 1'b0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    key_acc      = '0;
    bucket_count = TABLE_SIZE_RST;
    idle_en      = 1'b1;
    hold_req     = 0;
    hold_left    = 0;
    stall_left   = 0;
    errors       = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_and_idle_items();
    test_case_folding();
    test_table_size_extremes();
    test_output_backpressure();
    test_sender_pause();
    test_random_traffic();

    $display("covered %0d keys from %0d transactions, %0d results checked",
             keys_sent, items_sent, results_checked);
    $display("table sizes 0, 1, 2^31, 2^32-1 and random; input stalled %0d cycles",
             full_cycles);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== case_folded_key_bucket_hash.f =====
sv/ckbh_pkg.sv
sv/ckbh_front.sv
sv/ckbh_fifo.sv
sv/ckbh_back.sv
sv/case_folded_key_bucket_hash.sv
tb/testbench.sv
